### rtl/core/cdda_pkg.sv
// Package for the calendar date day arithmetic block: opcodes, field widths,
// year-start and month-start tables. No dependencies.
package cdda_pkg;

  localparam int unsigned EpochYear  = 1970;
  localparam int unsigned LastYear   = 2099;
  localparam int unsigned NumYears   = 130;
  localparam int unsigned LastDaynum = 47482;

  typedef logic [1:0]  opcode_t;
  typedef logic [4:0]  day_t;
  typedef logic [3:0]  month_t;
  typedef logic [11:0] year_t;
  typedef logic [15:0] daynum_t;
  typedef logic [7:0]  yidx_t;

  localparam opcode_t OP_ADD  = 2'd0;
  localparam opcode_t OP_SUB  = 2'd1;
  localparam opcode_t OP_DIFF = 2'd2;

  // Queue entry between the front and back parts.
  typedef struct packed {
    opcode_t op;
    daynum_t na;
    daynum_t nb;
    daynum_t off;
  } job_t;

  function automatic logic is_leap(input year_t y);
    return (y[1:0] == 2'b00) && (y != 12'd2100);
  endfunction

  // Days before 1 Jan of year index i (years since 1970).
  function automatic daynum_t year_start(input yidx_t i);
    logic [7:0] y;
    logic [7:0] leaps;
    y = i;
    // leap years 1972,1976,... before 1970+i
    leaps = (y + 8'd1) >> 2;
    return daynum_t'(y * 16'd365) + daynum_t'(leaps);
  endfunction

  // Days before day 1 of month m (1..12) in a non-leap year.
  function automatic logic [8:0] month_start(input month_t m);
    logic [8:0] r;
    case (m)
      4'd1:    r = 9'd0;
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  function automatic day_t month_len(input month_t m, input logic leap);
    day_t r;
    case (m)
      4'd2:                       r = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:    r = 5'd30;
      default:                    r = 5'd31;
    endcase
    return r;
  endfunction

endpackage

### rtl/core/cdda_front.sv
// Front part: validates dates A and B and turns them into day numbers.
// Depends on cdda_pkg.
module cdda_front import cdda_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  opcode_t in_op,
  input  day_t    in_day_a,
  input  month_t  in_month_a,
  input  year_t   in_year_a,
  input  day_t    in_day_b,
  input  month_t  in_month_b,
  input  year_t   in_year_b,
  input  daynum_t in_off,
  output logic    job_valid,
  input  logic    job_ready,
  output job_t    job
);

  logic vld_r, vld_nxt;
  job_t job_r, job_nxt;

  function automatic daynum_t to_daynum(input day_t d, input month_t m, input year_t y);
    logic   ok;
    logic   lp;
    yidx_t  yi;
    ok = (y >= year_t'(EpochYear)) && (y <= year_t'(LastYear)) &&
         (m >= 4'd1) && (m <= 4'd12);
    lp = is_leap(y);
    ok = ok && (d >= 5'd1) && (d <= month_len(m, lp));
    yi = yidx_t'(y - year_t'(EpochYear));
    if (!ok) return daynum_t'(1);
    return year_start(yi) + daynum_t'(month_start(m)) +
           daynum_t'((lp && m > 4'd2) ? 1 : 0) + daynum_t'(d);
  endfunction

  assign in_ready  = !vld_r || job_ready;
  assign job_valid = vld_r;
  assign job       = job_r;

  always_comb begin
    vld_nxt = vld_r;
    job_nxt = job_r;
    if (job_ready) vld_nxt = 1'b0;
    if (in_valid && in_ready) begin
      vld_nxt    = 1'b1;
      job_nxt.op = in_op;
      job_nxt.na = to_daynum(in_day_a, in_month_a, in_year_a);
      job_nxt.nb = to_daynum(in_day_b, in_month_b, in_year_b);
      job_nxt.off = in_off;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= 1'b0;
    else vld_r <= vld_nxt;
    job_r <= job_nxt;
  end

endmodule

### rtl/core/cdda_queue.sv
// Two-entry queue of jobs between the front and back parts.
// Depends on cdda_pkg.
module cdda_queue import cdda_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic wr_valid,
  output logic wr_ready,
  input  job_t wr_data,
  output logic rd_valid,
  input  logic rd_ready,
  output job_t rd_data
);

  job_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       wr, rd;

  assign wr_ready = cnt_r != 2'd2;
  assign rd_valid = cnt_r != 2'd0;
  assign rd_data  = mem_r[rp_r];
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (wr) wp_r <= !wp_r;
      if (rd) rp_r <= !rp_r;
      cnt_r <= cnt_r + 2'(wr) - 2'(rd);
    end
    if (wr) mem_r[wp_r] <= wr_data;
  end

  assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 2'd2)
    else $error("queue count overflow");
  assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd0 && wr) |=> rd_valid) else $error("queue lost write");
  assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd2 && !rd) |=> cnt_r == 2'd2) else $error("queue count drift");

endmodule

### rtl/core/cdda_back.sv
// Back part: computes the result day number and turns it back into a date
// with a year search (one year a cycle) then a month lookup. Depends on cdda_pkg.
module cdda_back import cdda_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    job_valid,
  output logic    job_ready,
  input  job_t    job,
  output logic    out_empty,
  input  logic    out_pop,
  output day_t    out_day,
  output month_t  out_month,
  output year_t   out_year,
  output daynum_t out_day_distance
);

  typedef enum logic [1:0] {S_IDLE, S_YEAR, S_MONTH, S_DONE} state_t;

  state_t     state_r;
  logic [16:0] n_r;       // zero-based day within range, later within year
  yidx_t      yi_r;
  day_t       day_r;
  month_t     mon_r;
  daynum_t    dist_r;
  logic [16:0] sum;
  logic [16:0] n0;
  logic        inrange;
  logic [8:0]  rem;
  logic        lp;
  month_t      mfound;
  logic [8:0]  mstart;
  daynum_t     ys_next;

  assign job_ready = (state_r == S_IDLE);
  assign out_empty = (state_r != S_DONE);
  assign out_day   = day_r;
  assign out_month = mon_r;
  assign out_year  = year_t'(EpochYear) + year_t'(yi_r);
  assign out_day_distance = dist_r;

  always_comb begin
    sum = (job.op == OP_ADD) ? 17'(job.na) + 17'(job.off) : 17'(job.na) - 17'(job.off);
    n0  = sum - 17'd1;
    inrange = (job.op == OP_ADD) ? (sum <= 17'(LastDaynum))
                                 : (job.op == OP_SUB) && (job.na > job.off);
  end

  assign ys_next = year_start(yi_r + yidx_t'(1));
  assign lp  = is_leap(year_t'(EpochYear) + year_t'(yi_r));
  assign rem = n_r[8:0];

  // Month lookup: largest month whose start (leap adjusted) is <= rem.
  always_comb begin
    mfound = 4'd1;
    mstart = 9'd0;
    for (int m = 2; m <= 12; m++) begin
      if (rem >= month_start(month_t'(m)) + 9'((lp && m > 2) ? 1 : 0)) begin
        mfound = month_t'(m);
        mstart = month_start(month_t'(m)) + 9'((lp && m > 2) ? 1 : 0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (job_valid) begin
            yi_r  <= '0;
            day_r <= 5'd1;
            mon_r <= 4'd1;
            dist_r <= (job.op != OP_DIFF) ? '0 :
                      (job.na >= job.nb) ? job.na - job.nb : job.nb - job.na;
            if (job.op == OP_DIFF) begin
              state_r <= S_DONE;
            end else if (inrange) begin
              n_r     <= n0;
              state_r <= S_YEAR;
            end else begin
              state_r <= S_DONE;
            end
          end
        end
        S_YEAR: begin
          if (n_r >= 17'(ys_next) && yi_r != yidx_t'(NumYears - 1)) begin
            yi_r <= yi_r + yidx_t'(1);
          end else begin
            n_r     <= n_r - 17'(year_start(yi_r));
            state_r <= S_MONTH;
          end
        end
        S_MONTH: begin
          mon_r   <= mfound;
          day_r   <= day_t'(rem - mstart + 9'd1);
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (out_pop) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && !out_pop) |=> state_r == S_DONE) else $error("result dropped");
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DONE |-> (mon_r >= 4'd1 && mon_r <= 4'd12)) else $error("bad month");
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DONE |-> day_r != 5'd0) else $error("bad day");

endmodule

### rtl/core/calendar_date_day_arithmetic.sv
// Calendar date day arithmetic, top level: front, job queue and back part.
// Depends on cdda_pkg, cdda_front, cdda_queue, cdda_back.
//
// Gregorian date arithmetic over 1970..2099. Opcode 0 adds offset_days to
// date A, opcode 1 subtracts it, opcode 2 gives the absolute day distance
// between A and B. Invalid dates count as 1 Jan 1970, and a result outside
// 1970..2099 comes back as 1 Jan 1970. Both sides look like queues: push an
// item when full is low, pop a result while empty is low. The front converts
// dates to day numbers through year and month start tables and registers them; a
// two-entry queue feeds the back part. Difference items, the unused opcode
// and add or subtract results out of range go straight from idle to done in
// the back part; other add and subtract items walk the year table one year a
// cycle and then take a month lookup before they are done. Only one result is held
// at a time; the front and queue keep accepting up to three items meanwhile.
module calendar_date_day_arithmetic import cdda_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [1:0]  in_opcode,
  input  logic [4:0]  in_day_a,
  input  logic [3:0]  in_month_a,
  input  logic [11:0] in_year_a,
  input  logic [4:0]  in_day_b,
  input  logic [3:0]  in_month_b,
  input  logic [11:0] in_year_b,
  input  logic [15:0] in_offset_days,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [4:0]  out_day,
  output logic [3:0]  out_month,
  output logic [11:0] out_year,
  output logic [15:0] out_day_distance
);

  logic in_ready;
  logic f_valid, f_ready;
  job_t f_job;
  logic q_valid, q_ready;
  job_t q_job;

  assign in_full = !in_ready;

  cdda_front u_front (
    .clk, .rst_n,
    .in_valid(in_push), .in_ready,
    .in_op(in_opcode), .in_day_a, .in_month_a, .in_year_a,
    .in_day_b, .in_month_b, .in_year_b, .in_off(in_offset_days),
    .job_valid(f_valid), .job_ready(f_ready), .job(f_job)
  );

  cdda_queue u_queue (
    .clk, .rst_n,
    .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_job),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_job)
  );

  cdda_back u_back (
    .clk, .rst_n,
    .job_valid(q_valid), .job_ready(q_ready), .job(q_job),
    .out_empty, .out_pop, .out_day, .out_month, .out_year, .out_day_distance
  );

endmodule

### tb/sv/tb.sv
// Testbench for calendar_date_day_arithmetic: directed table plus random dates,
// checked against an in-bench calendar predictor. Depends on cdda_pkg and the RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cdda_pkg::*;

  localparam int unsigned EndDaynum = 47482;
  localparam logic [1:0]  OP_SPARE  = 2'd3;

  typedef struct {
    logic [1:0]  op;
    logic [4:0]  da;
    logic [3:0]  ma;
    logic [11:0] ya;
    logic [4:0]  db;
    logic [3:0]  mb;
    logic [11:0] yb;
    logic [15:0] off;
  } date_item_t;

  typedef struct packed {
    logic [4:0]  d;
    logic [3:0]  m;
    logic [11:0] y;
    logic [15:0] span;
  } date_result_t;

  // directed row: item, typed-in expectation, whether that expectation is used
  typedef struct {
    date_item_t   it;
    date_result_t res;
    bit           typed;
  } date_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_push = 1'b0;
  logic        in_full;
  logic [1:0]  in_opcode = OP_ADD;
  logic [4:0]  in_day_a = '0;
  logic [3:0]  in_month_a = '0;
  logic [11:0] in_year_a = '0;
  logic [4:0]  in_day_b = '0;
  logic [3:0]  in_month_b = '0;
  logic [11:0] in_year_b = '0;
  logic [15:0] in_offset_days = '0;
  logic        out_empty;
  logic        out_pop = 1'b0;
  logic [4:0]  out_day;
  logic [3:0]  out_month;
  logic [11:0] out_year;
  logic [15:0] out_day_distance;

  date_result_t pending_dates[$];
  date_item_t   send_q[$];
  int unsigned  mismatches = 0;
  int unsigned  checked = 0;
  int unsigned  n_add = 0, n_sub = 0, n_diff = 0, n_bad = 0;
  bit           stim_done = 1'b0;
  bit           hold_off = 1'b0;

  always #10 clk = ~clk;

  calendar_date_day_arithmetic dut (.*);

  // ---------------- predictor ----------------
  function automatic bit leap_year(int unsigned y);
    return (y % 400 == 0) || (y % 4 == 0 && y % 100 != 0);
  endfunction

  function automatic int unsigned month_days(int unsigned m, int unsigned y);
    int unsigned lens[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    if (m == 2 && leap_year(y)) return 29;
    return lens[(m - 1) % 12];
  endfunction

  // invalid dates fold to 1 Jan 1970 (day 1)
  function automatic int unsigned date_to_daynum(int unsigned d, int unsigned m,
                                                 int unsigned y);
    int unsigned n;
    n = 0;
    if (y < EpochYear || y > LastYear || m < 1 || m > 12 || d < 1 ||
        d > month_days(m, y)) begin
      d = 1; m = 1; y = EpochYear;
    end
    for (int unsigned i = EpochYear; i < y; i++) n += leap_year(i) ? 366 : 365;
    for (int unsigned i = 1; i < m; i++) n += month_days(i, y);
    return n + d;
  endfunction

  function automatic date_result_t daynum_to_date(int unsigned n);
    date_result_t r;
    int unsigned  yy, mm, len;
    r = '{d: 5'd1, m: 4'd1, y: 12'(EpochYear), span: '0};
    if (n < 1 || n > EndDaynum) return r;
    yy = EpochYear;
    mm = 1;
    forever begin
      len = leap_year(yy) ? 366 : 365;
      if (n <= len) break;
      n -= len;
      yy++;
    end
    forever begin
      len = month_days(mm, yy);
      if (n <= len || mm >= 12) break;
      n -= len;
      mm++;
    end
    r.d = 5'(n);
    r.m = 4'(mm);
    r.y = 12'(yy);
    return r;
  endfunction

  function automatic date_result_t predict_date(date_item_t it);
    date_result_t r;
    int unsigned  na, nb;
    r = '{d: 5'd1, m: 4'd1, y: 12'(EpochYear), span: '0};
    na = date_to_daynum(it.da, it.ma, it.ya);
    case (it.op)
      OP_ADD: r = daynum_to_date(na + it.off);
      OP_SUB: if (na > it.off) r = daynum_to_date(na - it.off);
      OP_DIFF: begin
        nb = date_to_daynum(it.db, it.mb, it.yb);
        r.span = 16'(na >= nb ? na - nb : nb - na);
      end
      default: ;
    endcase
    return r;
  endfunction

  // ---------------- stimulus helpers ----------------
  function automatic date_item_t mk_item(logic [1:0] op, int da, int ma, int ya,
                                         int db, int mb, int yb, int off);
    date_item_t it;
    it = '{op: op, da: 5'(da), ma: 4'(ma), ya: 12'(ya), db: 5'(db), mb: 4'(mb),
           yb: 12'(yb), off: 16'(off)};
    return it;
  endfunction

  // mostly valid dates, now and then any bit pattern
  function automatic void rand_date(output logic [4:0] d, output logic [3:0] m,
                                    output logic [11:0] y);
    int unsigned yy, mm;
    if ($urandom_range(9) == 0) begin
      d = 5'($urandom);
      m = 4'($urandom);
      y = 12'($urandom);
    end else begin
      yy = $urandom_range(LastYear, EpochYear);
      mm = $urandom_range(12, 1);
      y = 12'(yy);
      m = 4'(mm);
      d = 5'($urandom_range(month_days(mm, yy), 1));
    end
  endfunction

  function automatic date_item_t rand_item();
    date_item_t it;
    int unsigned sel;
    sel = $urandom_range(99);
    it.op = sel < 40 ? OP_ADD : sel < 80 ? OP_SUB : sel < 97 ? OP_DIFF : OP_SPARE;
    rand_date(it.da, it.ma, it.ya);
    rand_date(it.db, it.mb, it.yb);
    // half the offsets are small; the rest are large, up to the whole range
    case ($urandom_range(3))
      0:       it.off = 16'($urandom_range(400));
      1:       it.off = 16'($urandom_range(5000));
      2:       it.off = 16'($urandom);
      default: it.off = 16'($urandom_range(47481, 40000));
    endcase
    return it;
  endfunction

  // ---------------- sender ----------------
  initial begin
    date_row_t  rows[$];
    date_item_t it;
    int         burst;
    date_result_t epoch;

    epoch = '{d: 5'd1, m: 4'd1, y: 12'(EpochYear), span: '0};
    // epoch + 0, epoch - 1 (before epoch), last day + 1 (past 2099)
    rows.push_back('{mk_item(OP_ADD, 1, 1, 1970, 0, 0, 0, 0), epoch, 1'b1});
    rows.push_back('{mk_item(OP_SUB, 1, 1, 1970, 0, 0, 0, 1), epoch, 1'b1});
    rows.push_back('{mk_item(OP_ADD, 31, 12, 2099, 0, 0, 0, 1), epoch, 1'b1});
    rows.push_back('{mk_item(OP_ADD, 31, 12, 2099, 0, 0, 0, 0),
                     '{5'd31, 4'd12, 12'd2099, 16'd0}, 1'b1});
    rows.push_back('{mk_item(OP_DIFF, 1, 1, 1970, 31, 12, 2099, 0),
                     '{5'd1, 4'd1, 12'(EpochYear), 16'd47481}, 1'b1});
    rows.push_back('{mk_item(OP_DIFF, 31, 12, 2099, 1, 1, 1970, 65535),
                     '{5'd1, 4'd1, 12'(EpochYear), 16'd47481}, 1'b1});
    // invalid dates: year, month, day and non-leap Feb 29
    rows.push_back('{mk_item(OP_ADD, 15, 6, 1969, 0, 0, 0, 0), epoch, 1'b1});
    rows.push_back('{mk_item(OP_ADD, 15, 6, 2100, 0, 0, 0, 0), epoch, 1'b1});
    rows.push_back('{mk_item(OP_ADD, 15, 13, 2000, 0, 0, 0, 0), epoch, 1'b1});
    rows.push_back('{mk_item(OP_ADD, 15, 0, 2000, 0, 0, 0, 0), epoch, 1'b1});
    rows.push_back('{mk_item(OP_ADD, 0, 5, 2000, 0, 0, 0, 0), epoch, 1'b1});
    rows.push_back('{mk_item(OP_ADD, 31, 4, 2000, 0, 0, 0, 0), epoch, 1'b1});
    rows.push_back('{mk_item(OP_ADD, 29, 2, 2001, 0, 0, 0, 0), epoch, 1'b1});
    rows.push_back('{mk_item(OP_ADD, 31, 15, 4095, 31, 15, 4095, 65535), epoch, 1'b1});
    // leap day valid in 2000 and 2096
    rows.push_back('{mk_item(OP_ADD, 29, 2, 2000, 0, 0, 0, 0),
                     '{5'd29, 4'd2, 12'd2000, 16'd0}, 1'b1});
    rows.push_back('{mk_item(OP_SUB, 1, 3, 2096, 0, 0, 0, 1),
                     '{5'd29, 4'd2, 12'd2096, 16'd0}, 1'b1});
    // unused opcode
    rows.push_back('{mk_item(OP_SPARE, 10, 10, 2010, 5, 5, 2005, 100), epoch, 1'b1});
    // predictor-checked rows
    rows.push_back('{mk_item(OP_ADD, 1, 1, 1970, 0, 0, 0, 65535), epoch, 1'b0});
    rows.push_back('{mk_item(OP_SUB, 31, 12, 2099, 0, 0, 0, 47481), epoch, 1'b0});
    rows.push_back('{mk_item(OP_SUB, 31, 12, 2099, 0, 0, 0, 47482), epoch, 1'b0});
    rows.push_back('{mk_item(OP_ADD, 28, 2, 2024, 0, 0, 0, 366), epoch, 1'b0});
    rows.push_back('{mk_item(OP_DIFF, 29, 2, 2024, 1, 3, 2023, 0), epoch, 1'b0});
    rows.push_back('{mk_item(OP_SUB, 15, 7, 2050, 0, 0, 0, 12345), epoch, 1'b0});

    foreach (rows[i]) begin
      if (rows[i].typed && predict_date(rows[i].it) != rows[i].res)
        $display("table row %0d disagrees with predictor", i);
      send_q.push_back(rows[i].it);
    end
    repeat (1000) send_q.push_back(rand_item());

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (send_q.size() != 0) begin
      burst = $urandom_range(30, 1);
      while (burst > 0 && send_q.size() != 0) begin
        it = send_q[0];
        in_push <= 1'b1;
        in_opcode <= it.op;
        in_day_a <= it.da;
        in_month_a <= it.ma;
        in_year_a <= it.ya;
        in_day_b <= it.db;
        in_month_b <= it.mb;
        in_year_b <= it.yb;
        in_offset_days <= it.off;
        @(posedge clk);
        if (!in_full) begin
          pending_dates.push_back(predict_date(it));
          case (it.op)
            OP_ADD:  n_add++;
            OP_SUB:  n_sub++;
            OP_DIFF: n_diff++;
            default: n_bad++;
          endcase
          void'(send_q.pop_front());
          burst--;
        end
      end
      if (send_q.size() != 0 && $urandom_range(2) != 0) begin
        in_push <= 1'b0;
        repeat ($urandom_range(20, 1)) @(posedge clk);
      end
    end
    in_push <= 1'b0;
    stim_done = 1'b1;
  end

  // ---------------- receiver ----------------
  // long hold-off once, early on, so the queue fills and in_full rises
  initial begin
    @(posedge rst_n);
    repeat (40) @(posedge clk);
    hold_off = 1'b1;
    repeat (600) @(posedge clk);
    hold_off = 1'b0;
  end

  // stall pattern: runs of pop high, then runs of pop low
  initial begin
    int run;
    int mode;
    mode = 0;
    run = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_pop && !out_empty) begin
        if (pending_dates.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %0d/%0d/%0d dist %0d",
                                         out_day, out_month, out_year, out_day_distance);
        end else begin
          date_result_t e;
          e = pending_dates.pop_front();
          checked++;
          if (out_day !== e.d || out_month !== e.m || out_year !== e.y ||
              out_day_distance !== e.span) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp %0d/%0d/%0d dist %0d, got %0d/%0d/%0d dist %0d",
                       e.d, e.m, e.y, e.span, out_day, out_month, out_year,
                       out_day_distance);
          end
        end
      end
      if (run == 0) begin
        mode = $urandom_range(3);
        run = $urandom_range(40, 1);
      end
      run--;
      out_pop <= !hold_off && (mode != 0);
    end
  end

  // ---------------- end of run ----------------
  initial begin
    wait (stim_done && pending_dates.size() == 0);
    repeat (200) @(posedge clk);
    $display("covered %0d add, %0d subtract, %0d difference, %0d unused-opcode items",
             n_add, n_sub, n_diff, n_bad);
    $display("%0d results checked, %0d mismatches", checked, mismatches);
    if (mismatches == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

  // worst case: all 1023 items, each with a full year walk, pop stalls and push gaps, plus hold-off
  initial begin
    #20ms;
    $display("timeout");
    $display("status: fail");
    $finish;
  end

endmodule
